>>> design/tia_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the transaction tag allocator.
package tia_pkg;

    localparam int SLOTS    = 64;
    localparam int TAG_BITS = 32;

    // Fixed widths of the request and result fields.
    localparam int OP_W  = 2;
    localparam int ID_W  = 6;
    localparam int TAG_W = 32;
    localparam int PND_W = 7;
    localparam int ST_W  = 2;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Free-slot search: groups of eight busy bits, with a register stage after the first level.
    localparam int GRP   = 8;
    localparam int GRP_W = 3;
    localparam int NGRP  = (SLOTS + GRP - 1) / GRP;
    localparam int PAD   = NGRP * GRP;

    // Compare width wide enough for both the request slot id and SLOTS.
    localparam int CMP_W = ((ID_W > SLOT_W) ? ID_W : SLOT_W) + 2;

    typedef enum logic [OP_W-1:0] {
        OP_GRAB    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    // Update commands from the sequencer to the slot tracker.
    typedef struct packed {
        logic              grab;
        logic              rel;
        logic              clr;
        logic [SLOT_W-1:0] idx;
    } t_trk_cmd;

    // Slot tracker status seen by the sequencer.
    typedef struct packed {
        logic              free_ok;
        logic [SLOT_W-1:0] free_idx;
        logic [CNT_W-1:0]  count;
        logic              q_busy;
    } t_trk_stat;

    // Lowest zero bit of an eight-bit group.
    function automatic logic [GRP_W:0] first_zero8(input logic [GRP-1:0] bits);
        logic [GRP_W:0] res;
        res = '0;
        for (int i = GRP - 1; i >= 0; i--) begin
            if (!bits[i]) begin
                res = {1'b1, GRP_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

>>> design/transaction_id_allocator.sv
`timescale 1ns / 1ps
// Top level of the transaction tag allocator: request sequencer and result register.
//
// Request channel (i_valid / o_stall): op, slot_id and tag_in. A request is
// taken at a rising edge with i_valid high and o_stall low.
// Result channel (o_valid / i_stall): status, slot_out, tag_out and
// pending_count; one result per request, in request order.
// A request passes through accept, a look cycle in which the tag
// memory is read and the busy bits pass the first level of the free-slot
// search, and an execute cycle that finishes the search, updates the busy
// bits and count and writes the tag memory. A new request is taken once the
// previous one has reached the result register, so requests do not overlap;
// the single memory read and the two-level registered search set the look and
// execute steps, and execute may stall on the result register as below.
// A result that waits in the result register does not block the next
// request from entering; that request holds in its execute cycle until the
// register frees up.
// Synchronous reset frees every slot, zeroes the pending count and empties
// the result register. Tag memory is not cleared; its read data is used only for
// slots that a grab has written.
module transaction_id_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [tia_pkg::OP_W-1:0]  i_op,
    input  logic [tia_pkg::ID_W-1:0]  i_slot_id,
    input  logic [tia_pkg::TAG_W-1:0] i_tag_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [tia_pkg::ST_W-1:0]  o_status,
    output logic [tia_pkg::ID_W-1:0]  o_slot_out,
    output logic [tia_pkg::TAG_W-1:0] o_tag_out,
    output logic [tia_pkg::PND_W-1:0] o_pending_count
);

    tia_pkg::t_state r_state;
    tia_pkg::t_state n_state;

    // Held request
    tia_pkg::t_op                 r_op;
    logic [tia_pkg::ID_W-1:0]     r_slot_id;
    logic [tia_pkg::TAG_BITS-1:0] r_tag;

    // Result register
    logic                      r_out_valid;
    logic [tia_pkg::ST_W-1:0]  r_status;
    logic [tia_pkg::ID_W-1:0]  r_slot_out;
    logic [tia_pkg::TAG_W-1:0] r_tag_out;
    logic [tia_pkg::PND_W-1:0] r_pending;

    logic [tia_pkg::ST_W-1:0]  n_status;
    logic [tia_pkg::ID_W-1:0]  n_slot_out;
    logic [tia_pkg::TAG_W-1:0] n_tag_out;
    logic [tia_pkg::PND_W-1:0] n_pending;

    logic                         w_accept;
    logic                         w_done;
    logic                         w_in_range;
    logic                         w_ram_we;
    logic                         w_ram_re;
    logic [tia_pkg::TAG_BITS-1:0] w_ram_rdata;
    logic [tia_pkg::SLOT_W-1:0]   w_slot_idx;

    tia_pkg::t_trk_cmd  w_cmd;
    tia_pkg::t_trk_stat w_stat;

    assign w_accept   = i_valid && !o_stall;
    // Execute finishes only when the result register is free or draining.
    assign w_done     = (r_state == tia_pkg::S_EXEC) && (!r_out_valid || !i_stall);
    assign w_in_range = tia_pkg::CMP_W'(r_slot_id) < tia_pkg::CMP_W'(tia_pkg::SLOTS);
    assign w_slot_idx = tia_pkg::SLOT_W'(r_slot_id);
    assign w_ram_re   = (r_state == tia_pkg::S_LOOK);

    tia_slot_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    tia_tag_ram #(
        .DEPTH (tia_pkg::SLOTS),
        .WIDTH (tia_pkg::TAG_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_stat.free_idx),
        .i_wdata (r_tag),
        .i_re    (w_ram_re),
        .i_raddr (w_slot_idx),
        .o_rdata (w_ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tia_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = tia_pkg::S_LOOK;
                end
            end
            tia_pkg::S_LOOK: begin
                n_state = tia_pkg::S_EXEC;
            end
            tia_pkg::S_EXEC: begin
                if (w_done) begin
                    n_state = tia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tia_pkg::S_IDLE;
            end
        endcase
    end

    // Execute: form the result and the state updates.
    always_comb begin
        w_cmd.grab = 1'b0;
        w_cmd.rel  = 1'b0;
        w_cmd.clr  = 1'b0;
        w_cmd.idx  = w_slot_idx;
        w_ram_we   = 1'b0;
        n_status   = tia_pkg::STS_OK;
        n_slot_out = r_slot_id;
        n_tag_out  = '0;
        n_pending  = tia_pkg::PND_W'(w_stat.count);
        unique case (r_op)
            tia_pkg::OP_GRAB: begin
                if (w_stat.free_ok) begin
                    w_cmd.grab = w_done;
                    w_ram_we   = w_done;
                    n_slot_out = tia_pkg::ID_W'(w_stat.free_idx);
                    n_pending  = tia_pkg::PND_W'(w_stat.count + tia_pkg::CNT_W'(1));
                end else begin
                    n_status = tia_pkg::STS_FULL;
                end
            end
            tia_pkg::OP_RELEASE: begin
                if (w_in_range && w_stat.q_busy) begin
                    w_cmd.rel = w_done;
                    n_pending = tia_pkg::PND_W'(w_stat.count - tia_pkg::CNT_W'(1));
                end else begin
                    n_status = tia_pkg::STS_NOT_USED;
                end
            end
            tia_pkg::OP_LOOKUP: begin
                if (w_in_range && w_stat.q_busy) begin
                    n_tag_out = tia_pkg::TAG_W'(w_ram_rdata);
                end else begin
                    n_status = tia_pkg::STS_NOT_USED;
                end
            end
            tia_pkg::OP_CLEAR: begin
                w_cmd.clr = w_done;
                n_pending = '0;
            end
            default: begin
                n_status = tia_pkg::STS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tia_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request on accept; load the result when execute finishes.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= tia_pkg::t_op'(i_op);
            r_slot_id <= i_slot_id;
            r_tag     <= tia_pkg::TAG_BITS'(i_tag_in);
        end
        if (w_done) begin
            r_status   <= n_status;
            r_slot_out <= n_slot_out;
            r_tag_out  <= n_tag_out;
            r_pending  <= n_pending;
        end
    end

    assign o_stall         = (r_state != tia_pkg::S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_slot_out      = r_slot_out;
    assign o_tag_out       = r_tag_out;
    assign o_pending_count = r_pending;

endmodule

>>> design/tia_tag_ram.sv
`timescale 1ns / 1ps
// Single-port-write, registered-read tag memory.
module tia_tag_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tia_slot_track.sv
`timescale 1ns / 1ps
// Busy bits, pending count and the registered lowest-free-slot search.
module tia_slot_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tia_pkg::t_trk_cmd i_cmd,
    output tia_pkg::t_trk_stat o_stat
);

    logic [tia_pkg::SLOTS-1:0] r_busy;
    logic [tia_pkg::SLOTS-1:0] n_busy;
    logic [tia_pkg::CNT_W-1:0] r_count;
    logic [tia_pkg::CNT_W-1:0] n_count;
    logic [tia_pkg::PAD-1:0]   w_busy_pad;

    logic [tia_pkg::GRP_W:0]   w_grp_enc  [tia_pkg::NGRP];
    logic                      r_grp_free [tia_pkg::NGRP];
    logic [tia_pkg::GRP_W-1:0] r_grp_idx  [tia_pkg::NGRP];

    logic                       w_free_ok;
    logic [tia_pkg::SLOT_W-1:0] w_free_idx;

    // Pad the top group with busy bits so it never yields a slot past the table.
    generate
        if (tia_pkg::PAD > tia_pkg::SLOTS) begin : g_pad
            assign w_busy_pad = {{(tia_pkg::PAD - tia_pkg::SLOTS){1'b1}}, r_busy};
        end else begin : g_nopad
            assign w_busy_pad = r_busy;
        end
    endgenerate

    // First level: per-group encode.
    always_comb begin
        for (int g = 0; g < tia_pkg::NGRP; g++) begin
            w_grp_enc[g] = tia_pkg::first_zero8(w_busy_pad[g*tia_pkg::GRP +: tia_pkg::GRP]);
        end
    end

    // Register the first level.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < tia_pkg::NGRP; g++) begin
            r_grp_free[g] <= w_grp_enc[g][tia_pkg::GRP_W];
            r_grp_idx[g]  <= w_grp_enc[g][tia_pkg::GRP_W-1:0];
        end
    end

    // Second level: lowest group with a free slot.
    always_comb begin
        w_free_ok  = 1'b0;
        w_free_idx = '0;
        for (int g = tia_pkg::NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_free_ok  = 1'b1;
                w_free_idx = tia_pkg::SLOT_W'(g * tia_pkg::GRP + int'(r_grp_idx[g]));
            end
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        priority if (i_cmd.clr) begin
            n_busy  = '0;
            n_count = '0;
        end else if (i_cmd.grab) begin
            n_busy[w_free_idx] = 1'b1;
            n_count            = r_count + tia_pkg::CNT_W'(1);
        end else if (i_cmd.rel) begin
            n_busy[i_cmd.idx] = 1'b0;
            n_count           = r_count - tia_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    assign o_stat.free_ok  = w_free_ok;
    assign o_stat.free_idx = w_free_idx;
    assign o_stat.count    = r_count;
    assign o_stat.q_busy   = r_busy[i_cmd.idx];

endmodule

>>> design/tia_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the transaction tag allocator, bound to its top level.
module tia_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [tia_pkg::OP_W-1:0]  i_op,
    input logic [tia_pkg::ID_W-1:0]  i_slot_id,
    input logic [tia_pkg::TAG_W-1:0] i_tag_in,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [tia_pkg::ST_W-1:0]  o_status,
    input logic [tia_pkg::ID_W-1:0]  o_slot_out,
    input logic [tia_pkg::TAG_W-1:0] o_tag_out,
    input logic [tia_pkg::PND_W-1:0] o_pending_count
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot_out)
                               && $stable(o_tag_out) && $stable(o_pending_count))
        else $error("stalled result changed");

    // A taken request keeps the request side stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request side not stalled after accept");

    // Full is reported only with every slot in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == tia_pkg::STS_FULL
        |-> o_pending_count == tia_pkg::PND_W'(tia_pkg::SLOTS))
        else $error("full status with free slots");

    // A failed request, for a slot not in use or a grab on a full table, yields no tag.
    a_unused_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == tia_pkg::STS_NOT_USED || o_status == tia_pkg::STS_FULL)
        |-> o_tag_out == '0)
        else $error("tag returned on failed request");

    // Pending count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pending_count <= tia_pkg::PND_W'(tia_pkg::SLOTS))
        else $error("pending count beyond table size");

endmodule

bind transaction_id_allocator tia_checker u_tia_checker (.*);
